>>> src/dtpb_pkg.sv
// ----------------------------------------------------------------------------
// dtpb_pkg
// shared constants and types of the dirty tile planar blitter
// ----------------------------------------------------------------------------
package dtpb_pkg;

   localparam int SCREEN_W    = 400;
   localparam int SCREEN_H    = 300;
   localparam int TILE_EDGE   = 8;
   localparam int DEST_STRIDE = 80;

   localparam int TILES_X   = (SCREEN_W + TILE_EDGE - 1) / TILE_EDGE;
   localparam int COL_W     = $clog2(TILES_X + 1);
   localparam int ROW_W     = $clog2(SCREEN_H + 1);
   localparam int PIX_DEPTH = SCREEN_H * TILES_X;
   localparam int PIX_AW    = $clog2(PIX_DEPTH);
   localparam int TX_AW     = $clog2(TILES_X);

   localparam int QDEPTH = 4;
   localparam int QAW    = 2;

   localparam logic CSR_OFFSET_X = 1'b0;
   localparam logic CSR_OFFSET_Y = 1'b1;

   typedef struct packed {
      logic [63:0] bytes;
      logic [2:0]  last_row;
      logic [15:0] dest;
   } job_type;

endpackage

>>> src/dtpb_front.sv
// ----------------------------------------------------------------------------
// dtpb_front
// accepts tile rows, diffs them against the previous frame, packs them and
// queues a blit job for each dirty tile at the end of a band
// ----------------------------------------------------------------------------
module dtpb_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,
   input  logic                 req_tuser,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [7:0]           csr_wdata,
   input  logic                 q_full,
   output logic                 q_push,
   output dtpb_pkg::job_type    q_job
);
   import dtpb_pkg::*;

   logic [COL_W-1:0]  col_ff, col_in, col_eff, col_s_ff;
   logic [ROW_W-1:0]  row_ff, row_in, row_eff, row_s_ff;
   logic              first_ff, first_in, busy_ff, fs_ff;
   logic [TILES_X-1:0] dirty_ff, dirty_in;
   logic [7:0]        off_x_ff, off_y_ff;
   logic [63:0]       item_ff, prev_rd_ff, band_rd_ff;
   logic [PIX_AW-1:0] pix_addr, addr_s_ff;
   logic              accept;

   logic [63:0] prev_mem [PIX_DEPTH];
   logic [63:0] band_mem [TILES_X];

   logic [7:0]  lane_ok;
   logic [7:0]  packed_row;
   logic        changed, dirty_now, end_band;
   logic [2:0]  br;
   logic [63:0] job_bytes;
   logic [9:0]  px;
   logic [16:0] row_prod;

   assign req_tready = !busy_ff && !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_eff = (req_tuser || col_ff >= COL_W'(TILES_X)) ? '0 : col_ff;
      row_eff = (req_tuser || row_ff >= ROW_W'(SCREEN_H)) ? '0 : row_ff;
      pix_addr = PIX_AW'(row_eff) * PIX_AW'(TILES_X) + PIX_AW'(col_eff);
   end

   // second stage: compare, pack, mark dirty
   always_comb begin
      br = row_s_ff[2:0];
      for (int i = 0; i < 8; i++) begin
         lane_ok[i]        = (32'(col_s_ff) * 8 + i) < SCREEN_W;
         packed_row[7 - i] = item_ff[8 * i + 7];
      end
      changed = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (lane_ok[i] && prev_rd_ff[8 * i +: 8] != item_ff[8 * i +: 8]) begin
            changed = 1'b1;
         end
      end
      dirty_in = fs_ff ? '0 : dirty_ff;
      dirty_now = dirty_in[col_s_ff[TX_AW-1:0]] | changed | first_ff;
      end_band = (br == 3'(TILE_EDGE - 1)) || (row_s_ff == ROW_W'(SCREEN_H - 1));
      dirty_in[col_s_ff[TX_AW-1:0]] = end_band ? 1'b0 : dirty_now;

      job_bytes = band_rd_ff;
      job_bytes[{br, 3'b000} +: 8] = packed_row;
      px = 10'(off_x_ff) + 10'({col_s_ff, 3'b000});
      row_prod = (17'(off_y_ff) + 17'(row_s_ff) - 17'(br)) * 17'(DEST_STRIDE);
      q_job.bytes    = job_bytes;
      q_job.last_row = br;
      q_job.dest     = row_prod[15:0] + 16'(px[9:3]);
      q_push = busy_ff && end_band && dirty_now;

      col_in   = col_s_ff + 1'b1;
      row_in   = row_s_ff;
      first_in = first_ff;
      if (col_in >= COL_W'(TILES_X)) begin
         col_in = '0;
         row_in = row_s_ff + 1'b1;
         if (row_in >= ROW_W'(SCREEN_H)) begin
            row_in   = '0;
            first_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         first_ff <= 1'b1;
         busy_ff  <= 1'b0;
         dirty_ff <= '0;
         off_x_ff <= 8'd120;
         off_y_ff <= 8'd90;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_OFFSET_X) begin
               off_x_ff <= csr_wdata;
            end else begin
               off_y_ff <= csr_wdata;
            end
         end
         busy_ff <= accept;
         if (busy_ff) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            first_ff <= first_in;
            dirty_ff <= dirty_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff    <= req_tdata;
         fs_ff      <= req_tuser;
         col_s_ff   <= col_eff;
         row_s_ff   <= row_eff;
         addr_s_ff  <= pix_addr;
         prev_rd_ff <= prev_mem[pix_addr];
         band_rd_ff <= band_mem[col_eff[TX_AW-1:0]];
      end
      if (busy_ff) begin
         for (int i = 0; i < 8; i++) begin
            if (lane_ok[i]) begin
               prev_mem[addr_s_ff][8 * i +: 8] <= item_ff[8 * i +: 8];
            end
         end
         band_mem[col_s_ff[TX_AW-1:0]][{br, 3'b000} +: 8] <= packed_row;
      end
   end

endmodule

>>> src/dtpb_queue.sv
// ----------------------------------------------------------------------------
// dtpb_queue
// short job queue between the diff front and the blit back
// ----------------------------------------------------------------------------
module dtpb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dtpb_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output dtpb_pkg::job_type pop_job
);
   import dtpb_pkg::*;

   job_type        mem_ff [QDEPTH];
   logic [QAW-1:0] wr_ff, rd_ff;
   logic [QAW:0]   cnt_ff;

   assign full    = cnt_ff == (QAW + 1)'(QDEPTH);
   assign empty   = cnt_ff == '0;
   assign pop_job = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QAW + 1)'(push) - (QAW + 1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("job pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("job popped from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QAW + 1)'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

>>> src/dtpb_back.sv
// ----------------------------------------------------------------------------
// dtpb_back
// plays out a queued tile job as one result per row
// ----------------------------------------------------------------------------
module dtpb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   output logic              q_pop,
   input  dtpb_pkg::job_type q_job,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,
   output logic              rsp_tlast
);
   import dtpb_pkg::*;

   logic        have_ff;
   job_type     job_ff;
   logic [2:0]  r_ff;
   logic [15:0] dest_ff;

   assign q_pop      = !have_ff && !q_empty;
   assign rsp_tvalid = have_ff;
   assign rsp_tlast  = r_ff == job_ff.last_row;
   assign rsp_tdata  = {job_ff.bytes[{r_ff, 3'b000} +: 8], dest_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (q_pop) begin
         have_ff <= 1'b1;
      end else if (have_ff && rsp_tready && rsp_tlast) begin
         have_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff  <= q_job;
         r_ff    <= '0;
         dest_ff <= q_job.dest;
      end else if (have_ff && rsp_tready) begin
         r_ff    <= r_ff + 1'b1;
         dest_ff <= dest_ff + 16'(DEST_STRIDE);
      end
   end

endmodule

>>> src/dirty_tile_planar_blitter_top.sv
// ----------------------------------------------------------------------------
// dirty_tile_planar_blitter_top
// frame difference blitter: emits packed rows of changed 8x8 tiles
// ----------------------------------------------------------------------------
// Each transaction on req is one 8-pixel tile row in raster order. The front
// reads the previous-frame word and the band word, then compares, writes back
// and updates the dirty marks, and takes no new row while busy with the last,
// so the previous-frame memory port sets the rate. At the last row of a band
// a dirty tile becomes a job in a 4-entry queue; the back emits one rsp per
// row, up to 8, and pops a job only once the last row of the one before is
// taken. The front stalls while busy or while the queue is full. Every tile
// is dirty in the first frame. The memories need no clearing pass.
module dirty_tile_planar_blitter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // pixel_0 .. pixel_7, 8 bits each
   input  logic        req_tuser,   // frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // dest_offset[15:0], packed_byte[23:16]
   output logic        rsp_tlast,   // last_of_tile
   input  logic        csr_we,
   input  logic        csr_index,   // 0 offset_x, 1 offset_y
   input  logic [7:0]  csr_wdata
);
   import dtpb_pkg::*;

   logic    q_full, q_push, q_pop, q_empty;
   job_type push_job, pop_job;

   // diff and classify
   dtpb_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .q_full(q_full), .q_push(q_push), .q_job(push_job)
   );

   // decoupling queue
   dtpb_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_job(push_job), .full(q_full),
      .pop(q_pop), .empty(q_empty), .pop_job(pop_job)
   );

   // row playout
   dtpb_back u_back (
      .clock(clock), .reset(reset),
      .q_empty(q_empty), .q_pop(q_pop), .q_job(pop_job),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the dirty tile planar blitter: tile rows go in on
// req, a behavioral predictor tracks the previous frame, band buffer and
// dirty marks, and every rsp transaction is compared with the oldest
// predicted byte
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dtpb_pkg::*;

   localparam int CYCLE_LIMIT = 40000;
   localparam int DRAIN_CYCLES = 24;

   typedef struct {
      logic [15:0] dest;
      logic [7:0]  packed_px;
      logic        last;
   } blit_byte_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;     // pixel_0 .. pixel_7, 8 bits each
   logic        req_tuser;     // frame_start
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;     // dest_offset[15:0], packed_byte[23:16]
   logic        rsp_tlast;     // last_of_tile
   logic        csr_we;
   logic        csr_index;
   logic [7:0]  csr_wdata;

   // predictor state
   logic [7:0]  prev_pix [SCREEN_W*SCREEN_H];
   logic [7:0]  band_rows [TILE_EDGE*TILES_X];
   bit          tile_dirty [TILES_X];
   bit          in_first_frame;
   int          cur_col;
   int          cur_row;
   logic [7:0]  shadow_off_x;
   logic [7:0]  shadow_off_y;

   blit_byte_type pending_bytes [$];
   int          error_count;
   int          cycle_count;

   // idling controls
   bit          no_idle;
   int          rsp_hold_cycles;

   dirty_tile_planar_blitter_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // cycle counter with a generous limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // work out the bytes one accepted tile row produces
   task automatic predict_row(input bit fs, input logic [63:0] pix);
      int          row_in_band;
      int          x0;
      int          base_y;
      int          byte_x;
      bit          changed;
      logic [7:0]  p;
      logic [7:0]  packed_px;
      blit_byte_type b;
      changed = 1'b0;
      packed_px = '0;
      if (fs) begin
         cur_col = 0;
         cur_row = 0;
         foreach (tile_dirty[k]) tile_dirty[k] = 1'b0;
      end
      row_in_band = cur_row % TILE_EDGE;
      x0 = cur_col * TILE_EDGE;
      for (int i = 0; i < 8; i++) begin
         p = pix[8*i +: 8];
         if (x0 + i < SCREEN_W) begin
            if (prev_pix[cur_row*SCREEN_W + x0 + i] !== p) changed = 1'b1;
            prev_pix[cur_row*SCREEN_W + x0 + i] = p;
         end
         packed_px[7-i] = p[7];
      end
      band_rows[row_in_band*TILES_X + cur_col] = packed_px;
      if (changed || in_first_frame) tile_dirty[cur_col] = 1'b1;
      // band ends on its last row or on the last screen row (partial band)
      if (row_in_band == TILE_EDGE-1 || cur_row == SCREEN_H-1) begin
         if (tile_dirty[cur_col]) begin
            base_y = cur_row - row_in_band;
            byte_x = (int'(shadow_off_x) + x0) / 8;
            for (int r = 0; r <= row_in_band; r++) begin
               b.dest = 16'((int'(shadow_off_y) + base_y + r) * DEST_STRIDE + byte_x);
               b.packed_px = band_rows[r*TILES_X + cur_col];
               b.last = (r == row_in_band);
               pending_bytes.push_back(b);
            end
         end
         tile_dirty[cur_col] = 1'b0;
      end
      cur_col++;
      if (cur_col >= TILES_X) begin
         cur_col = 0;
         cur_row++;
         if (cur_row >= SCREEN_H) begin
            cur_row = 0;
            in_first_frame = 1'b0;
         end
      end
   endtask

   // one tile row transaction, with random gaps before it
   task automatic send_row(input bit fs, input logic [63:0] pix);
      while (!no_idle && $urandom_range(99) < 22) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = fs;
      req_tdata = pix;
      do @(posedge clock); while (!req_tready);
      predict_row(fs, pix);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0) @(negedge clock);
      // a row that makes no bytes may still be in the pipe
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_offsets(input logic [7:0] ox, input logic [7:0] oy);
      wait_drained();
      csr_we = 1'b1;
      csr_index = CSR_OFFSET_X;
      csr_wdata = ox;
      @(negedge clock);
      csr_index = CSR_OFFSET_Y;
      csr_wdata = oy;
      @(negedge clock);
      csr_we = 1'b0;
      shadow_off_x = ox;
      shadow_off_y = oy;
   endtask

   // pixels that mostly repeat the stored frame at the current position
   function automatic logic [63:0] near_prev_row(input int change_pct);
      logic [63:0] pix;
      int          x0;
      x0 = cur_col * TILE_EDGE;
      for (int i = 0; i < 8; i++) begin
         if ($urandom_range(99) < change_pct) pix[8*i +: 8] = 8'($urandom);
         else pix[8*i +: 8] = prev_pix[cur_row*SCREEN_W + x0 + i];
      end
      return pix;
   endfunction

   // extremes of the pixel fields and a frame restart in the middle of a row
   task automatic test_pixel_extremes();
      send_row(1'b1, {8{8'h00}});
      send_row(1'b0, {8{8'hFF}});
      send_row(1'b0, {4{8'h80, 8'h7F}});
      send_row(1'b0, {4{8'h7F, 8'h80}});
      send_row(1'b0, 64'h0102_0408_1020_4080);
      send_row(1'b0, 64'hFEFD_FBF7_EFDF_BF7F);
      // restart discards the dirty marks of the band in progress
      send_row(1'b1, {8{8'h55}});
      send_row(1'b0, {8{8'hAA}});
      for (int n = 0; n < 12; n++)
         send_row(1'b0, {$urandom, $urandom});
   endtask

   // first full band of the first frame, every tile dirty; offsets change
   // between jobs once all bytes are out, with a long rsp hold-off and a pause
   task automatic test_first_frame();
      logic [63:0] pix;
      send_row(1'b1, {$urandom, $urandom});
      while (cur_row < TILE_EDGE) begin
         if (cur_col == 0 && cur_row == 5) write_offsets(8'd240, 8'd180);
         if (cur_col == 0 && cur_row == TILE_EDGE-1) rsp_hold_cycles = 300;
         if (cur_col == 20 && cur_row == TILE_EDGE-1) begin
            // sender holds off until every byte is out
            while (pending_bytes.size() != 0) @(negedge clock);
         end
         if (cur_col == 35 && cur_row == TILE_EDGE-1) write_offsets(8'd7, 8'd13);
         if (cur_col == 45 && cur_row == TILE_EDGE-1) write_offsets(8'd0, 8'd0);
         no_idle = (cur_row == 6);
         if ($urandom_range(3) == 0) pix = {$urandom, $urandom};
         else pix = {8{8'($urandom_range(1) ? 8'hFF : 8'h00)}};
         send_row(1'b0, pix);
      end
      no_idle = 1'b0;
   endtask

   // restarts within the stored rows: mostly unchanged rows with edits
   task automatic test_changed_tiles();
      int sent;
      bit fs;
      write_offsets(8'd121, 8'd90);
      sent = 0;
      while (sent < 24) begin
         fs = (sent == 0) || ($urandom_range(199) == 0);
         if (fs) begin
            cur_col = 0;
            cur_row = 0;
         end
         case ($urandom_range(9))
            0:       send_row(fs, {$urandom, $urandom});
            1, 2:    send_row(fs, near_prev_row(10));
            default: send_row(fs, near_prev_row(0));
         endcase
         sent++;
      end
   endtask

   // rsp backpressure: random stalls plus a long counted hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 22);
      end
   end

   // compare each rsp transaction with the oldest predicted byte
   always @(posedge clock) begin
      blit_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            $error("unexpected rsp transaction: data %h last %b", rsp_tdata, rsp_tlast);
            error_count <= error_count + 1;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata[15:0] !== want.dest) begin
               $error("dest_offset: expected %0d actual %0d", want.dest, rsp_tdata[15:0]);
               error_count <= error_count + 1;
            end
            if (rsp_tdata[23:16] !== want.packed_px) begin
               $error("packed_byte: expected %h actual %h", want.packed_px,
                      rsp_tdata[23:16]);
               error_count <= error_count + 1;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_tile: expected %b actual %b", want.last, rsp_tlast);
               error_count <= error_count + 1;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_OFFSET_X;
      csr_wdata = '0;
      no_idle = 1'b0;
      rsp_hold_cycles = 0;
      error_count = 0;
      cycle_count = 0;
      in_first_frame = 1'b1;
      cur_col = 0;
      cur_row = 0;
      shadow_off_x = 8'd120;
      shadow_off_y = 8'd90;
      foreach (tile_dirty[k]) tile_dirty[k] = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_pixel_extremes();
      test_first_frame();
      test_changed_tiles();

      wait_drained();
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
